/* src/mvt_pkg.sv */
// shared types and constants for the 4x4 matrix-vector transform
package mvt_pkg;

  localparam int COEF_W        = 32;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int REG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PIPE_DEPTH    = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COLS-1:0] row_t;
  typedef row_t [NUM_ROWS-1:0] mat_t;
  typedef coef_t [NUM_COLS-1:0] vec_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] vec_x;
    logic signed [COEF_W-1:0] vec_y;
    logic signed [COEF_W-1:0] vec_z;
    logic signed [COEF_W-1:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_w;
    logic                     overflow;
  } out_item_t;

  localparam coef_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam coef_t SAT_MIN = 32'sh8000_0000;

  // identity in Q16.16, register 7 first
  localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

endpackage

/* src/mvt_cfg_regs.sv */
// matrix configuration registers with identity reset
module mvt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mvt_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [mvt_pkg::REG_W-1:0]     cfg_wdata,
  output mvt_pkg::mat_t                 mat_o
);
  import mvt_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0] regs_r;
  logic [NUM_REGS-1:0][REG_W-1:0] regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      regs_nxt[cfg_idx] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // two registers per row, even columns in the low half
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        mat_o[r][c] = regs_r[r*2 + c/2][(c%2)*COEF_W +: COEF_W];
      end
    end
  end

endmodule

/* src/mvt_row_dot.sv */
// one matrix row dotted with the vector: multiply, two add levels, shift and saturate
module mvt_row_dot #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  mvt_pkg::row_t row_i,
  input  mvt_pkg::vec_t vec_i,
  output mvt_pkg::coef_t res_o,
  output logic          sat_o
);
  import mvt_pkg::*;

  localparam int PROD_W = 2 * COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int HI_LSB = FRAC_BITS + COEF_W - 1;

  logic signed [PROD_W-1:0] prod_r   [NUM_COLS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_COLS];
  logic signed [PAIR_W-1:0] pair_r   [2];
  logic signed [PAIR_W-1:0] pair_nxt [2];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  coef_t                    res_r;
  coef_t                    res_nxt;
  logic                     sat_r;
  logic                     sat_nxt;
  logic [SUM_W-HI_LSB-1:0]  sum_hi;

  // stage 1: four 32x32 products
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      prod_nxt[c] = PROD_W'($signed(row_i[c])) * PROD_W'($signed(vec_i[c]));
    end
  end

  // stage 2 and 3: exact sums, sign extended at each level
  always_comb begin
    pair_nxt[0] = {prod_r[0][PROD_W-1], prod_r[0]} + {prod_r[1][PROD_W-1], prod_r[1]};
    pair_nxt[1] = {prod_r[2][PROD_W-1], prod_r[2]} + {prod_r[3][PROD_W-1], prod_r[3]};
    sum_nxt     = {pair_r[0][PAIR_W-1], pair_r[0]} + {pair_r[1][PAIR_W-1], pair_r[1]};
  end

  // stage 4: floor shift, fits when everything above the result is sign
  always_comb begin
    sum_hi = sum_r[SUM_W-1:HI_LSB];
    if ((&sum_hi) || !(|sum_hi)) begin
      res_nxt = sum_r[FRAC_BITS +: COEF_W];
      sat_nxt = 1'b0;
    end else begin
      res_nxt = sum_r[SUM_W-1] ? SAT_MIN : SAT_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pair_r <= pair_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule

/* src/matrix4_vector_transform_core.sv */
// top level of the 4x4 matrix times vector transform, signed Q16.16
//
// A vector beat is taken at each clock edge where start is high; busy is
// always low, so a new vector may follow in every cycle. The result beat
// shows on out_data with out_strobe high for exactly one cycle, after the
// product, pair, sum and result registers (one vector per cycle).
// The receiver cannot hold results off, so nothing in the pipe ever waits.
// Each output component is one matrix row dotted with the vector, summed
// exactly, shifted right by FRAC_BITS with floor, then saturated to 32 bits;
// overflow is set when any component saturated.
// The pipe is set by the 32x32 multipliers in the first stage, followed by
// two adder levels and the shift/saturate stage, one row unit per output.
// The matrix sits in eight 64-bit registers written through cfg_we, cfg_idx
// and cfg_wdata; write them only while no vector is in flight.
// Synchronous reset clears the pipe valid bits and loads the identity
// matrix; payload registers are not reset.
module matrix4_vector_transform_core #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mvt_pkg::in_item_t             in_data,
  output logic                          out_strobe,
  output mvt_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mvt_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [mvt_pkg::REG_W-1:0]     cfg_wdata
);
  import mvt_pkg::*;

  mat_t                  mat;
  vec_t                  vec;
  coef_t                 res    [NUM_ROWS];
  logic [NUM_ROWS-1:0]   sat;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;

  // the pipe never stalls
  assign busy = 1'b0;

  assign vec[0] = in_data.vec_x;
  assign vec[1] = in_data.vec_y;
  assign vec[2] = in_data.vec_z;
  assign vec[3] = in_data.vec_w;

  mvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mat_o     (mat)
  );

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    mvt_row_dot #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk   (clk),
      .row_i (mat[r]),
      .vec_i (vec),
      .res_o (res[r]),
      .sat_o (sat[r])
    );
  end

  // valid bits follow the beat through the row units
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_strobe        = vld_r[PIPE_DEPTH-1];
  assign out_data.out_x    = res[0];
  assign out_data.out_y    = res[1];
  assign out_data.out_z    = res[2];
  assign out_data.out_w    = res[3];
  assign out_data.overflow = |sat;

`ifndef SYNTHESIS
  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_DEPTH))
    else $error("result beat without a vector taken four cycles before");

  a_overflow_means_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.overflow) |->
      (out_data.out_x == SAT_MAX || out_data.out_x == SAT_MIN ||
       out_data.out_y == SAT_MAX || out_data.out_y == SAT_MIN ||
       out_data.out_z == SAT_MAX || out_data.out_z == SAT_MIN ||
       out_data.out_w == SAT_MAX || out_data.out_w == SAT_MIN))
    else $error("overflow flagged but no component clamped");

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result beat right after reset");
`endif

endmodule
